[sv/lsir_pkg.sv]
// Shared types, constants and register codes for the laser scan island remover.
package lsir_pkg;

	localparam int DEF_MAX_POINTS = 2048;

	localparam int IDX_W   = 11;
	localparam int RANGE_W = 16;
	localparam int CNT_W   = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WALL_STEP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ISLAND   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_REPEAT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_POINTS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_LENGTH  = 3'd5;

	localparam logic [RANGE_W-1:0] RST_MAX_DISTANCE = 16'd400;
	localparam logic [RANGE_W-1:0] RST_WALL_STEP    = 16'd50;
	localparam logic [CNT_W-1:0]   RST_MIN_ISLAND   = 12'd10;
	localparam logic [CNT_W-1:0]   RST_MIN_REPEAT   = 12'd10;
	localparam logic [CNT_W-1:0]   RST_SKIP_POINTS  = 12'd360;
	localparam logic [CNT_W-1:0]   RST_SCAN_LENGTH  = 12'd1024;

	localparam logic [RANGE_W:0] FAR_OFFSET_MM = 17'd1000;
	localparam logic [CNT_W-1:0] COUNT_MAX     = 12'd4095;

	typedef struct packed {
		logic [RANGE_W-1:0] max_distance_mm;
		logic [RANGE_W-1:0] wall_step_mm;
		logic [CNT_W-1:0]   min_island_points;
		logic [CNT_W-1:0]   min_repeat_points;
		logic [CNT_W-1:0]   skip_points;
		logic [CNT_W-1:0]   scan_length;
	} cfg_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} flag_rd_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic             close;
	} flag_wr_t;

endpackage

[sv/lsir_if.sv]
// Valid/ready channel interfaces for range samples and removal runs.
interface lsir_in_if;
	logic                          valid;
	logic                          ready;
	logic [lsir_pkg::IDX_W-1:0]    sample_index;
	logic [lsir_pkg::RANGE_W-1:0]  range_mm;
	logic                          range_missing;
	logic                          scan_start;

	modport source (output valid, output sample_index, output range_mm,
		output range_missing, output scan_start, input ready);
	modport sink (input valid, input sample_index, input range_mm,
		input range_missing, input scan_start, output ready);
endinterface

interface lsir_out_if;
	logic                        valid;
	logic                        ready;
	logic [lsir_pkg::IDX_W-1:0]  run_start;
	logic [lsir_pkg::CNT_W-1:0]  run_length;

	modport source (output valid, output run_start, output run_length, input ready);
	modport sink (input valid, input run_start, input run_length, output ready);
endinterface

[sv/laser_scan_island_remover_core.sv]
// Top level of the laser scan island remover: config registers, flag store, sample stage.
// A sample item is held in the sample stage, then its run, if any, in the result register.
// Throughput: one item per cycle unless runs stall; single sample stage, flag store port.
// Reset: clears control and restores config defaults; the flag store then runs a clearing
// pass over all MAX_POINTS flags, in which no item is accepted (config writes still taken).
module laser_scan_island_remover_core #(
	parameter int MAX_POINTS = lsir_pkg::DEF_MAX_POINTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lsir_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lsir_pkg::CFG_DATA_W-1:0]   cfg_data,
	lsir_in_if.sink                           samples,
	lsir_out_if.source                        runs
);
	lsir_pkg::cfg_t     cfg_q;
	lsir_pkg::flag_rd_t rd;
	lsir_pkg::flag_wr_t wr;
	logic               prev_flag;
	logic               store_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_distance_mm   <= lsir_pkg::RST_MAX_DISTANCE;
			cfg_q.wall_step_mm      <= lsir_pkg::RST_WALL_STEP;
			cfg_q.min_island_points <= lsir_pkg::RST_MIN_ISLAND;
			cfg_q.min_repeat_points <= lsir_pkg::RST_MIN_REPEAT;
			cfg_q.skip_points       <= lsir_pkg::RST_SKIP_POINTS;
			cfg_q.scan_length       <= lsir_pkg::RST_SCAN_LENGTH;
		end else if (cfg_we) begin
			case (cfg_index)
				lsir_pkg::REG_MAX_DISTANCE: cfg_q.max_distance_mm <= cfg_data;
				lsir_pkg::REG_WALL_STEP:    cfg_q.wall_step_mm <= cfg_data;
				lsir_pkg::REG_MIN_ISLAND:   cfg_q.min_island_points <= cfg_data[lsir_pkg::CNT_W-1:0];
				lsir_pkg::REG_MIN_REPEAT:   cfg_q.min_repeat_points <= cfg_data[lsir_pkg::CNT_W-1:0];
				lsir_pkg::REG_SKIP_POINTS:  cfg_q.skip_points <= cfg_data[lsir_pkg::CNT_W-1:0];
				lsir_pkg::REG_SCAN_LENGTH:  cfg_q.scan_length <= cfg_data[lsir_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lsir_flag_mem #(
		.MAX_POINTS (MAX_POINTS)
	) u_flag_mem (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd          (rd),
		.wr          (wr),
		.rd_flag     (prev_flag),
		.store_ready (store_ready)
	);

	lsir_proc u_proc (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.store_ready (store_ready),
		.prev_flag   (prev_flag),
		.rd          (rd),
		.wr          (wr),
		.samples     (samples),
		.runs        (runs)
	);

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		!store_ready |-> !samples.ready)
		else $error("item accepted during flag clearing pass");

	a_store_stays_ready: assert property (@(posedge clk) disable iff (!arst_n)
		store_ready |=> store_ready)
		else $error("flag store left ready state");

	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		runs.valid |-> (runs.run_length != '0))
		else $error("removal run with zero length");

	a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		!store_ready |-> !wr.en)
		else $error("flag write during clearing pass");

endmodule

[sv/lsir_flag_mem.sv]
// Previous-scan close flag store with clearing pass after reset and write bypass.
module lsir_flag_mem #(
	parameter int MAX_POINTS = lsir_pkg::DEF_MAX_POINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lsir_pkg::flag_rd_t rd,
	input  lsir_pkg::flag_wr_t wr,
	output logic               rd_flag,
	output logic               store_ready
);
	localparam int AW = $clog2(MAX_POINTS);

	logic          mem [MAX_POINTS];
	logic [AW-1:0] clr_cnt_q;
	logic          clearing_q;
	logic          raw_q;
	logic          byp_q;
	logic          byp_val_q;
	logic          oor_q;
	logic          wr_ok;
	logic          rd_ok;

	assign wr_ok = wr.en && (32'(wr.idx) < MAX_POINTS);
	assign rd_ok = 32'(rd.idx) < MAX_POINTS;
	assign store_ready = !clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(MAX_POINTS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_cnt_q] <= 1'b0;
		end else if (wr_ok) begin
			mem[AW'(wr.idx)] <= wr.close;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			raw_q     <= mem[AW'(rd.idx)];
			byp_q     <= wr.en && (wr.idx == rd.idx);
			byp_val_q <= wr.close;
			oor_q     <= !rd_ok;
		end
	end

	assign rd_flag = oor_q ? 1'b0 : (byp_q ? byp_val_q : raw_q);

endmodule

[sv/lsir_proc.sv]
// Sample stage, per-scan island state and result register.
module lsir_proc (
	input  logic               clk,
	input  logic               arst_n,
	input  lsir_pkg::cfg_t     cfg,
	input  logic               store_ready,
	input  logic               prev_flag,
	output lsir_pkg::flag_rd_t rd,
	output lsir_pkg::flag_wr_t wr,
	lsir_in_if.sink            samples,
	lsir_out_if.source         runs
);
	logic                         valid_s1;
	logic [lsir_pkg::IDX_W-1:0]   idx_s1;
	logic [lsir_pkg::RANGE_W-1:0] range_s1;
	logic                         missing_s1;
	logic                         start_s1;

	logic                         last_close_q;
	logic [lsir_pkg::CNT_W-1:0]   island_cnt_q;
	logic [lsir_pkg::CNT_W-1:0]   repeat_cnt_q;
	logic [lsir_pkg::RANGE_W:0]   last_range_q;
	logic                         last_missing_q;

	logic                         out_valid_q;
	logic [lsir_pkg::IDX_W-1:0]   run_start_q;
	logic [lsir_pkg::CNT_W-1:0]   run_length_q;

	logic                         accept;
	logic                         out_free;
	logic                         adv;

	logic                         lc_eff;
	logic [lsir_pkg::CNT_W-1:0]   ic_eff;
	logic [lsir_pkg::CNT_W-1:0]   rc_eff;
	logic [lsir_pkg::RANGE_W:0]   lr_eff;
	logic                         lrm_eff;

	logic signed [12:0]           upper;
	logic signed [12:0]           idx_sx;
	logic                         in_band;
	logic                         step_ok;
	logic signed [17:0]           dr;
	logic signed [17:0]           ws_sx;
	logic signed [17:0]           dr_plus;
	logic                         rise;
	logic                         drop;
	logic                         lc_w;
	logic [lsir_pkg::RANGE_W:0]   r_eff;
	logic                         close;
	logic [lsir_pkg::CNT_W-1:0]   ic_inc;
	logic [lsir_pkg::CNT_W-1:0]   rc_inc;
	logic                         emit;

	assign accept   = samples.valid && samples.ready;
	assign out_free = !out_valid_q || runs.ready;
	assign adv      = valid_s1 && out_free;
	assign samples.ready = store_ready && (!valid_s1 || out_free);

	assign rd.en  = accept;
	assign rd.idx = samples.sample_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1     <= samples.sample_index;
			range_s1   <= samples.range_mm;
			missing_s1 <= samples.range_missing;
			start_s1   <= samples.scan_start;
		end
	end

	// scan start clears per-scan state before the sample is handled
	assign lc_eff  = start_s1 ? 1'b0 : last_close_q;
	assign ic_eff  = start_s1 ? '0 : island_cnt_q;
	assign rc_eff  = start_s1 ? '0 : repeat_cnt_q;
	assign lr_eff  = start_s1 ? '0 : last_range_q;
	assign lrm_eff = start_s1 ? 1'b0 : last_missing_q;

	assign upper   = $signed({1'b0, cfg.scan_length}) - $signed({1'b0, cfg.skip_points});
	assign idx_sx  = $signed({2'b00, idx_s1});
	assign in_band = ({1'b0, idx_s1} <= cfg.skip_points) || (idx_sx >= upper);

	assign step_ok = !missing_s1 && !lrm_eff;
	assign dr      = $signed({2'b00, range_s1}) - $signed({1'b0, lr_eff});
	assign ws_sx   = $signed({2'b00, cfg.wall_step_mm});
	assign dr_plus = dr + ws_sx;
	assign rise    = step_ok && (dr >= ws_sx);
	assign drop    = step_ok && !rise && (dr_plus <= 18'sd0);
	assign lc_w    = rise ? 1'b0 : lc_eff;
	assign r_eff   = drop ? ({1'b0, cfg.max_distance_mm} + lsir_pkg::FAR_OFFSET_MM)
	                      : {1'b0, range_s1};
	assign close   = !missing_s1 && (r_eff < {1'b0, cfg.max_distance_mm});

	assign ic_inc  = (ic_eff == lsir_pkg::COUNT_MAX) ? ic_eff : ic_eff + 1'b1;
	assign rc_inc  = (prev_flag && (rc_eff != lsir_pkg::COUNT_MAX)) ? rc_eff + 1'b1 : rc_eff;
	assign emit    = in_band && !close && lc_w &&
	                 ((ic_eff < cfg.min_island_points) || (rc_eff < cfg.min_repeat_points));

	assign wr.en    = adv && in_band;
	assign wr.idx   = idx_s1;
	assign wr.close = close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_close_q   <= 1'b0;
			island_cnt_q   <= '0;
			repeat_cnt_q   <= '0;
			last_range_q   <= '0;
			last_missing_q <= 1'b0;
		end else if (adv) begin
			if (in_band) begin
				last_close_q   <= close;
				island_cnt_q   <= close ? ic_inc : '0;
				repeat_cnt_q   <= close ? rc_inc : '0;
				last_range_q   <= r_eff;
				last_missing_q <= missing_s1;
			end else begin
				last_close_q   <= lc_eff;
				island_cnt_q   <= ic_eff;
				repeat_cnt_q   <= rc_eff;
				last_range_q   <= lr_eff;
				last_missing_q <= lrm_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end else if (runs.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			run_start_q  <= idx_s1 - ic_eff[lsir_pkg::IDX_W-1:0];
			run_length_q <= ic_eff;
		end
	end

	assign runs.valid      = out_valid_q;
	assign runs.run_start  = run_start_q;
	assign runs.run_length = run_length_q;

endmodule

[tb/tb_laser_scan_island_remover_core.sv]
// Testbench for laser_scan_island_remover_core: predicts removal runs per sample item.
`timescale 1ns / 100ps

module tb_laser_scan_island_remover_core;

	localparam int STALL_LIMIT = 10000;
	localparam int SCAN_BUDGET = 180;

	typedef struct packed {
		logic [lsir_pkg::IDX_W-1:0]   idx;
		logic [lsir_pkg::RANGE_W-1:0] range_mm;
		logic                         missing;
		logic                         start;
	} sample_t;

	typedef struct packed {
		logic [lsir_pkg::IDX_W-1:0] run_start;
		logic [lsir_pkg::CNT_W-1:0] run_length;
	} run_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [lsir_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lsir_pkg::CFG_DATA_W-1:0] cfg_data;

	lsir_in_if  samples_if ();
	lsir_out_if runs_if ();

	laser_scan_island_remover_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_if),
		.runs      (runs_if)
	);

	sample_t samples_due[$];
	run_t    runs_due[$];
	sample_t head_sample;
	sample_t seen_sample;
	run_t    want_run;

	lsir_pkg::cfg_t             cfg;
	logic                       prev_close [lsir_pkg::DEF_MAX_POINTS];
	logic                       last_close;
	logic [lsir_pkg::CNT_W-1:0] island_len;
	logic [lsir_pkg::CNT_W-1:0] repeat_len;
	logic [lsir_pkg::RANGE_W:0] last_range;
	logic                       last_missing;

	bit shape [lsir_pkg::DEF_MAX_POINTS];

	int queued_items   = 0;
	int accepted_items = 0;
	int errors         = 0;
	int stall_cycles   = 0;
	int send_idle_pct  = 17;
	int recv_idle_pct  = 54;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit in_edge(input int idx);
		return idx <= int'(cfg.skip_points) ||
			idx >= int'(cfg.scan_length) - int'(cfg.skip_points);
	endfunction

	function automatic void track_island(input sample_t s);
		logic [lsir_pkg::RANGE_W:0] r;
		logic                       close_now;
		int                         diff;
		if (s.start) begin
			last_close   = 1'b0;
			island_len   = '0;
			repeat_len   = '0;
			last_range   = '0;
			last_missing = 1'b0;
		end
		if (!in_edge(int'(s.idx)))
			return;
		r = {1'b0, s.range_mm};
		if (!s.missing && !last_missing) begin
			diff = int'(r) - int'(last_range);
			if (diff >= int'(cfg.wall_step_mm))
				last_close = 1'b0;
			else if (diff <= -int'(cfg.wall_step_mm))
				r = {1'b0, cfg.max_distance_mm} + lsir_pkg::FAR_OFFSET_MM;
		end
		close_now = !s.missing && (r < {1'b0, cfg.max_distance_mm});
		if (close_now) begin
			if (island_len != lsir_pkg::COUNT_MAX)
				island_len++;
			if (prev_close[s.idx] && repeat_len != lsir_pkg::COUNT_MAX)
				repeat_len++;
		end else begin
			if (last_close && (island_len < cfg.min_island_points ||
					repeat_len < cfg.min_repeat_points))
				runs_due.push_back(run_t'{s.idx - island_len[lsir_pkg::IDX_W-1:0],
					island_len});
			island_len = '0;
			repeat_len = '0;
		end
		last_close         = close_now;
		prev_close[s.idx]  = close_now;
		last_range         = r;
		last_missing       = s.missing;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= 100)
			$display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	task automatic queue_sample(input int idx, input int r, input bit missing, input bit start);
		sample_t s;
		s.idx      = idx[lsir_pkg::IDX_W-1:0];
		s.range_mm = r[lsir_pkg::RANGE_W-1:0];
		s.missing  = missing;
		s.start    = start;
		samples_due.push_back(s);
		queued_items++;
	endtask

	task automatic write_reg(input logic [lsir_pkg::CFG_IDX_W-1:0] which, input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value[lsir_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (which)
			lsir_pkg::REG_MAX_DISTANCE: cfg.max_distance_mm   = value[lsir_pkg::RANGE_W-1:0];
			lsir_pkg::REG_WALL_STEP:    cfg.wall_step_mm      = value[lsir_pkg::RANGE_W-1:0];
			lsir_pkg::REG_MIN_ISLAND:   cfg.min_island_points = value[lsir_pkg::CNT_W-1:0];
			lsir_pkg::REG_MIN_REPEAT:   cfg.min_repeat_points = value[lsir_pkg::CNT_W-1:0];
			lsir_pkg::REG_SKIP_POINTS:  cfg.skip_points       = value[lsir_pkg::CNT_W-1:0];
			lsir_pkg::REG_SCAN_LENGTH:  cfg.scan_length       = value[lsir_pkg::CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int max_mm, input int wall_mm, input int min_isl,
			input int min_rep, input int skip, input int len);
		write_reg(lsir_pkg::REG_MAX_DISTANCE, max_mm);
		write_reg(lsir_pkg::REG_WALL_STEP, wall_mm);
		write_reg(lsir_pkg::REG_MIN_ISLAND, min_isl);
		write_reg(lsir_pkg::REG_MIN_REPEAT, min_rep);
		write_reg(lsir_pkg::REG_SKIP_POINTS, skip);
		write_reg(lsir_pkg::REG_SCAN_LENGTH, len);
	endtask

	task automatic wait_idle();
		while (accepted_items != queued_items || runs_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic int pick_range(input bit near);
		int spread;
		int v;
		spread = int'(cfg.wall_step_mm) / 2;
		if (spread < 1)
			spread = 1;
		if (spread > 3000)
			spread = 3000;
		if (near)
			v = int'(cfg.max_distance_mm) - 1 - int'($urandom_range(0, spread - 1));
		else if ($urandom_range(0, 3) != 0)
			v = int'(cfg.max_distance_mm) + int'($urandom_range(0, spread - 1));
		else
			v = int'($urandom_range(int'(cfg.max_distance_mm), 65535));
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v;
	endfunction

	task automatic build_shape();
		int  i;
		int  run;
		int  isl_cap;
		bit  on;
		isl_cap = (cfg.min_island_points > 18) ? 40 : 2 * int'(cfg.min_island_points) + 3;
		i  = 0;
		on = $urandom_range(0, 1);
		while (i < lsir_pkg::DEF_MAX_POINTS) begin
			run = on ? $urandom_range(1, isl_cap) : $urandom_range(1, 6);
			while (run > 0 && i < lsir_pkg::DEF_MAX_POINTS) begin
				shape[i] = on;
				i++;
				run--;
			end
			on = !on;
		end
	endtask

	// Scans follow the island shape with small changes from scan to scan, plus noise.
	task automatic queue_scans(input int budget, input int mid_keep);
		int  sent;
		int  i;
		int  r;
		int  nidx;
		bit  first;
		bit  near;
		bit  start;
		sent = 0;
		while (sent < budget) begin
			first = 1'b1;
			for (i = 0; i < int'(cfg.scan_length); i++) begin
				if (!in_edge(i) && $urandom_range(1, mid_keep) != 1)
					continue;
				near  = shape[i] ^ ($urandom_range(0, 11) == 0);
				r     = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 65535) : pick_range(near);
				start = first ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 99) == 0);
				queue_sample(i, r, $urandom_range(0, 19) == 0, start);
				first = 1'b0;
				if (in_edge(i))
					sent++;
				if ($urandom_range(0, 39) == 0) begin
					nidx = $urandom_range(0, lsir_pkg::DEF_MAX_POINTS - 1);
					queue_sample(nidx, $urandom_range(0, 65535), $urandom_range(0, 1),
						$urandom_range(0, 7) == 0);
					if (in_edge(nidx))
						sent++;
				end
			end
		end
	endtask

	task automatic run_phase(input int max_mm, input int wall_mm, input int min_isl,
			input int min_rep, input int skip, input int len, input int budget);
		apply_setting(max_mm, wall_mm, min_isl, min_rep, skip, len);
		build_shape();
		queue_scans(budget, (len > 1024) ? 64 : 4);
		wait_idle();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_if.valid         <= 1'b0;
			samples_if.sample_index  <= '0;
			samples_if.range_mm      <= '0;
			samples_if.range_missing <= 1'b0;
			samples_if.scan_start    <= 1'b0;
		end else if (!samples_if.valid || samples_if.ready) begin
			if (samples_due.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				head_sample = samples_due.pop_front();
				samples_if.valid         <= 1'b1;
				samples_if.sample_index  <= head_sample.idx;
				samples_if.range_mm      <= head_sample.range_mm;
				samples_if.range_missing <= head_sample.missing;
				samples_if.scan_start    <= head_sample.start;
			end else begin
				samples_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runs_if.ready <= 1'b0;
		end else begin
			runs_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			if (samples_if.valid && samples_if.ready) begin
				seen_sample.idx      = samples_if.sample_index;
				seen_sample.range_mm = samples_if.range_mm;
				seen_sample.missing  = samples_if.range_missing;
				seen_sample.start    = samples_if.scan_start;
				track_island(seen_sample);
				accepted_items++;
			end
			if (runs_if.valid && runs_if.ready) begin
				if (runs_due.size() == 0) begin
					report_mismatch("unexpected run, start", int'(runs_if.run_start), -1);
				end else begin
					want_run = runs_due.pop_front();
					if (runs_if.run_start !== want_run.run_start)
						report_mismatch("run_start", int'(runs_if.run_start),
							int'(want_run.run_start));
					if (runs_if.run_length !== want_run.run_length)
						report_mismatch("run_length", int'(runs_if.run_length),
							int'(want_run.run_length));
				end
			end
			if ((samples_if.valid && samples_if.ready) || (runs_if.valid && runs_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int k;
		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_index                = '0;
		cfg_data                 = '0;
		for (k = 0; k < lsir_pkg::DEF_MAX_POINTS; k++)
			prev_close[k] = 1'b0;
		last_close   = 1'b0;
		island_len   = '0;
		repeat_len   = '0;
		last_range   = '0;
		last_missing = 1'b0;
		cfg.max_distance_mm   = lsir_pkg::RST_MAX_DISTANCE;
		cfg.wall_step_mm      = lsir_pkg::RST_WALL_STEP;
		cfg.min_island_points = lsir_pkg::RST_MIN_ISLAND;
		cfg.min_repeat_points = lsir_pkg::RST_MIN_REPEAT;
		cfg.skip_points       = lsir_pkg::RST_SKIP_POINTS;
		cfg.scan_length       = lsir_pkg::RST_SCAN_LENGTH;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed edges under the reset setting.
		queue_sample(0, 100, 0, 1);
		queue_sample(1, 120, 0, 0);
		queue_sample(2, 0, 0, 0);
		queue_sample(3, 0, 1, 0);
		queue_sample(4, 65535, 0, 0);
		queue_sample(5, 65535, 1, 0);
		queue_sample(6, 399, 0, 0);
		queue_sample(7, 380, 0, 0);
		queue_sample(8, 400, 0, 0);
		queue_sample(9, 390, 0, 0);
		queue_sample(10, 450, 0, 0);
		queue_sample(500, 100, 0, 1);
		queue_sample(360, 100, 0, 0);
		queue_sample(361, 100, 0, 0);
		queue_sample(663, 100, 0, 0);
		queue_sample(664, 120, 0, 0);
		queue_sample(665, 0, 1, 0);
		queue_sample(2047, 65535, 0, 1);
		queue_sample(1024, 0, 0, 0);
		queue_sample(0, 1, 0, 1);
		queue_sample(1, 2, 0, 0);
		queue_sample(2, 3, 0, 0);
		queue_sample(3, 60, 0, 0);
		queue_sample(4, 5000, 0, 0);
		wait_idle();

		run_phase(400, 50, 10, 10, 8, 40, SCAN_BUDGET);
		run_phase(1000, 200, 3, 2, 12, 32, SCAN_BUDGET);

		send_idle_pct = 54;
		recv_idle_pct = 17;
		run_phase(65534, 65535, 2048, 2048, 2048, 64, SCAN_BUDGET);
		run_phase(0, 0, 0, 0, 0, 1, 80);
		run_phase(2000, 100, 5, 0, 16, 2048, SCAN_BUDGET);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(800, 30, 0, 6, 20, 48, SCAN_BUDGET);
		run_phase(500, 80, 4, 3, 30, 50, SCAN_BUDGET);

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
